[src/dbt_pkg.sv]
// ----------------------------------------------------------------------------
// dbt_pkg
// Types and constants shared by the button debounce / edge tracker modules.
// ----------------------------------------------------------------------------
package dbt_pkg;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_IRQ    = 2'd1,
        REQ_READ   = 2'd2,
        REQ_RESET  = 2'd3
    } t_req;

    localparam logic [15:0] DELAY_RESET = 16'd50;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        pin_pressed;
        logic [31:0] now_ms;
    } t_dbt_in;

    typedef struct packed {
        logic        is_pressed;
        logic        press_event;
        logic        release_event;
        logic        level_changed;
        logic [31:0] presses_total;
        logic [31:0] press_stamp;
        logic [31:0] release_stamp;
    } t_dbt_out;

endpackage

[src/button_debounce_edge_tracker.sv]
// ----------------------------------------------------------------------------
// button_debounce_edge_tracker
// Timer based debouncer and edge tracker for one active-low push button.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one request item (sample, interrupt,
// read-and-clear, reset tracking) with the raw pin level and a ms timestamp.
// Output channel o_valid/i_stall returns exactly one result item per request:
// debounced level, single-shot flags, press count and press/release stamps.
// An item is taken when valid is high and stall is low.
// Each accepted request passes the input register, then the update logic
// feeding the result register. Throughput: 1 item per cycle while the
// receiver does not stall; the tracker state loops back through the update
// logic, so each item sees the previous one's state.
// Receiver stall: the result register holds; the input register still takes
// one more item if it is empty, then o_stall rises until the result is taken.
// Debounce delay register is written by i_cfg_we/i_cfg_wdata; the user must
// write it only while idle (not enforced). Reset (synchronous, i_rst_n low):
// all state cleared, delay to 50 ms, both channels empty; no clearing pass.
// ----------------------------------------------------------------------------
module button_debounce_edge_tracker #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  dbt_pkg::t_dbt_in  i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output dbt_pkg::t_dbt_out o_item
);
    import dbt_pkg::*;

    logic    w_in_valid;
    t_dbt_in w_in_item;
    logic    w_adv;

    dbt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    dbt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (w_in_valid),
        .i_in_item   (w_in_item),
        .o_adv       (w_adv),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

[src/dbt_in_reg.sv]
// ----------------------------------------------------------------------------
// dbt_in_reg
// Input register stage: holds one request item until the core takes it.
// ----------------------------------------------------------------------------
module dbt_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dbt_pkg::t_dbt_in i_item,
    input  logic             i_adv,
    output logic             o_valid,
    output dbt_pkg::t_dbt_in o_item
);
    import dbt_pkg::*;

    logic    r_valid;
    t_dbt_in r_item;
    logic    w_load;

    assign o_stall = r_valid && !i_adv;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/dbt_core.sv]
// ----------------------------------------------------------------------------
// dbt_core
// Debounce state, flag and stamp update, and the result register.
// ----------------------------------------------------------------------------
module dbt_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    input  dbt_pkg::t_dbt_in  i_in_item,
    output logic              o_adv,
    output logic              o_valid,
    input  logic              i_stall,
    output dbt_pkg::t_dbt_out o_item
);
    import dbt_pkg::*;

    localparam int TW = TIME_BITS;

    logic [15:0]   r_delay;
    logic          r_prior;
    logic          r_stable;
    logic          r_older;
    logic          r_changed;
    logic          r_pressed;
    logic          r_released;
    logic          r_irq;
    logic [TW-1:0] r_last;
    logic [TW-1:0] r_press_t;
    logic [TW-1:0] r_release_t;
    logic [31:0]   r_cnt;
    logic          r_out_valid;
    t_dbt_out      r_out;

    logic          n_prior;
    logic          n_stable;
    logic          n_older;
    logic          n_changed;
    logic          n_pressed;
    logic          n_released;
    logic          n_irq;
    logic [TW-1:0] n_last;
    logic [TW-1:0] n_press_t;
    logic [TW-1:0] n_release_t;
    logic [31:0]   n_cnt;
    t_dbt_out      n_out;

    logic             w_level;
    logic [TW+31:0]   w_now_ext;
    logic [TW-1:0]    w_now;
    logic [TW-1:0]    w_edge_t;
    logic [TW-1:0]    w_diff;
    logic [TW+15:0]   w_diff_ext;
    logic [TW+15:0]   w_delay_ext;
    logic             w_acc;
    logic [TW+31:0]   w_ps_ext;
    logic [TW+31:0]   w_rs_ext;
    t_req             w_req;

    assign o_adv   = i_in_valid && (!r_out_valid || !i_stall);
    assign w_req   = t_req'(i_in_item.req_type);
    assign w_level = i_in_item.pin_pressed;

    assign w_now_ext   = {{TW{1'b0}}, i_in_item.now_ms};
    assign w_now       = w_now_ext[TW-1:0];
    assign w_edge_t    = (w_level != r_prior) ? w_now : r_last;
    assign w_diff      = w_now - w_edge_t;
    assign w_diff_ext  = {16'd0, w_diff};
    assign w_delay_ext = {{TW{1'b0}}, r_delay};

    always_comb begin
        n_prior     = r_prior;
        n_stable    = r_stable;
        n_older     = r_older;
        n_changed   = r_changed;
        n_pressed   = r_pressed;
        n_released  = r_released;
        n_irq       = r_irq;
        n_last      = r_last;
        n_press_t   = r_press_t;
        n_release_t = r_release_t;
        n_cnt       = r_cnt;
        w_acc       = 1'b0;

        unique case (w_req)
            REQ_SAMPLE: begin
                if (r_irq) begin
                    n_irq = 1'b0;
                    w_acc = 1'b1;
                end else begin
                    n_last  = w_edge_t;
                    w_acc   = w_diff_ext > w_delay_ext;
                    n_prior = w_level;
                end
            end
            REQ_IRQ: begin
                n_irq = 1'b1;
            end
            REQ_READ: begin
            end
            REQ_RESET: begin
                n_prior    = w_level;
                n_stable   = w_level;
                n_older    = w_level;
                n_changed  = 1'b0;
                n_pressed  = 1'b0;
                n_released = 1'b0;
                n_last     = w_now;
                n_cnt      = 32'd0;
            end
            default: begin
            end
        endcase

        if (w_acc) begin
            n_older   = r_stable;
            n_stable  = w_level;
            n_changed = n_stable != n_older;
            if (n_changed && w_level) begin
                n_pressed  = 1'b1;
                n_released = 1'b0;
                n_press_t  = w_now;
                n_cnt      = r_cnt + 32'd1;
            end else if (n_changed) begin
                n_pressed   = 1'b0;
                n_released  = 1'b1;
                n_release_t = w_now;
            end else begin
                n_pressed  = 1'b0;
                n_released = 1'b0;
            end
        end
    end

    assign w_ps_ext = {32'd0, n_press_t};
    assign w_rs_ext = {32'd0, n_release_t};

    always_comb begin
        n_out.is_pressed    = n_stable;
        n_out.press_event   = n_pressed;
        n_out.release_event = n_released;
        n_out.level_changed = n_changed;
        n_out.presses_total = n_cnt;
        n_out.press_stamp   = w_ps_ext[31:0];
        n_out.release_stamp = w_rs_ext[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior     <= 1'b0;
            r_stable    <= 1'b0;
            r_older     <= 1'b0;
            r_changed   <= 1'b0;
            r_pressed   <= 1'b0;
            r_released  <= 1'b0;
            r_irq       <= 1'b0;
            r_last      <= '0;
            r_press_t   <= '0;
            r_release_t <= '0;
            r_cnt       <= 32'd0;
        end else if (o_adv) begin
            r_prior     <= n_prior;
            r_stable    <= n_stable;
            r_older     <= n_older;
            r_irq       <= n_irq;
            r_last      <= n_last;
            r_press_t   <= n_press_t;
            r_release_t <= n_release_t;
            r_cnt       <= n_cnt;
            // read request clears the single-shot flags after reporting them
            if (w_req == REQ_READ) begin
                r_changed  <= 1'b0;
                r_pressed  <= 1'b0;
                r_released <= 1'b0;
            end else begin
                r_changed  <= n_changed;
                r_pressed  <= n_pressed;
                r_released <= n_released;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pressed && r_released))
        else $error("press and release flags both set");

    a_changed_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_changed == (r_pressed || r_released))
        else $error("changed flag out of step with press/release flags");

    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_pressed == r_stable && r_out.presses_total == r_cnt))
        else $error("result register out of step with tracker state");

    a_reset_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && w_req == REQ_RESET) |=> (r_cnt == 32'd0 && r_out.presses_total == 32'd0))
        else $error("reset tracking did not clear the press count");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && w_req != REQ_RESET)
            |=> (r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + 32'd1))
        else $error("press count moved by more than one");
`endif

endmodule

[tb/button_debounce_edge_tracker_sb.sv]
// ----------------------------------------------------------------------------
// button_debounce_edge_tracker_sb
// Watches both item channels and the delay register write port of the
// debouncer. Keeps its own copy of the tracker state, computes the expected
// result for every request taken, and compares each returned result field by
// field in order. Hands the number of mismatches and the number of results
// still awaited back to the testbench top.
// ----------------------------------------------------------------------------
module button_debounce_edge_tracker_sb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  dbt_pkg::t_dbt_in  i_req,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  dbt_pkg::t_dbt_out i_res,
    output int                o_fail_count,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dbt_pkg::*;

    localparam int MAX_PRINTS = 60;

    logic [15:0] delay_ms;
    logic        last_raw;
    logic        level;
    logic        prev_level;
    logic        chg;
    logic        pressed;
    logic        released;
    logic        irq_armed;
    logic [31:0] edge_time;
    logic [31:0] press_time;
    logic [31:0] release_time;
    logic [31:0] press_count;

    t_dbt_out expected_results[$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS) begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    function automatic void take_level(input logic lvl, input logic [31:0] now);
        prev_level = level;
        level      = lvl;
        chg        = (level != prev_level);
        if (chg) begin
            if (level) begin
                pressed     = 1'b1;
                released    = 1'b0;
                press_time  = now;
                press_count = press_count + 32'd1;
            end else begin
                pressed      = 1'b0;
                released     = 1'b1;
                release_time = now;
            end
        end else begin
            pressed  = 1'b0;
            released = 1'b0;
        end
    endfunction

    function automatic t_dbt_out predict_result(input t_dbt_in rq);
        t_dbt_out    r;
        logic [31:0] quiet;
        case (t_req'(rq.req_type))
            REQ_SAMPLE: begin
                if (irq_armed) begin
                    irq_armed = 1'b0;
                    take_level(rq.pin_pressed, rq.now_ms);
                end else begin
                    if (rq.pin_pressed != last_raw) begin
                        edge_time = rq.now_ms;
                    end
                    quiet = rq.now_ms - edge_time;
                    if (quiet > {16'd0, delay_ms}) begin
                        take_level(rq.pin_pressed, rq.now_ms);
                    end
                    last_raw = rq.pin_pressed;
                end
            end
            REQ_IRQ: begin
                irq_armed = 1'b1;
            end
            REQ_READ: begin
            end
            REQ_RESET: begin
                last_raw    = rq.pin_pressed;
                level       = rq.pin_pressed;
                prev_level  = rq.pin_pressed;
                chg         = 1'b0;
                pressed     = 1'b0;
                released    = 1'b0;
                edge_time   = rq.now_ms;
                press_count = '0;
            end
        endcase
        r.is_pressed    = level;
        r.press_event   = pressed;
        r.release_event = released;
        r.level_changed = chg;
        r.presses_total = press_count;
        r.press_stamp   = press_time;
        r.release_stamp = release_time;
        if (t_req'(rq.req_type) == REQ_READ) begin
            pressed  = 1'b0;
            released = 1'b0;
            chg      = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dbt_out want;
        if (!i_rst_n) begin
            delay_ms     = DELAY_RESET;
            last_raw     = 1'b0;
            level        = 1'b0;
            prev_level   = 1'b0;
            chg          = 1'b0;
            pressed      = 1'b0;
            released     = 1'b0;
            irq_armed    = 1'b0;
            edge_time    = '0;
            press_time   = '0;
            release_time = '0;
            press_count  = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                delay_ms = i_cfg_wdata;
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results.push_back(predict_result(i_req));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("is_pressed", 32'(i_res.is_pressed),
                                32'(want.is_pressed));
                    check_field("press_event", 32'(i_res.press_event),
                                32'(want.press_event));
                    check_field("release_event", 32'(i_res.release_event),
                                32'(want.release_event));
                    check_field("level_changed", 32'(i_res.level_changed),
                                32'(want.level_changed));
                    check_field("presses_total", i_res.presses_total,
                                want.presses_total);
                    check_field("press_stamp", i_res.press_stamp, want.press_stamp);
                    check_field("release_stamp", i_res.release_stamp,
                                want.release_stamp);
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

[tb/button_debounce_edge_tracker_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_edge_tracker_tb
// Drives request items into the debouncer: a directed run through bounce,
// quiet-time boundary, interrupt, read-and-clear, tracking reset and timer
// wrap cases, then random button traces under several delay settings with
// sender gaps, receiver stalls and two long receiver hold-offs. Results are
// checked by the scoreboard module; this top gives the verdict.
// ----------------------------------------------------------------------------
module button_debounce_edge_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dbt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        req_valid;
    logic        req_stall;
    t_dbt_in     req_item;
    logic        res_valid;
    logic        res_stall;
    t_dbt_out    res_item;

    int fail_count;
    int outstanding;
    int cycle_cnt = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    button_debounce_edge_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_item      (req_item),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_item      (res_item)
    );

    button_debounce_edge_tracker_sb i_sb (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .i_req         (req_item),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_res         (res_item),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("button_debounce_edge_tracker_tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_stall <= 1'b1;
                hold_left--;
            end else begin
                res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic t_dbt_in make_req(input t_req kind, input logic pin,
                                         input logic [31:0] now);
        t_dbt_in r;
        r.req_type    = kind;
        r.pin_pressed = pin;
        r.now_ms      = now;
        return r;
    endfunction

    task automatic offer_request(input t_dbt_in it);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_delay(input logic [15:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] d, input int idle, input int stall,
                             input int n_items, input int hold_at);
        logic [31:0] t;
        logic [31:0] step;
        logic        pin;
        int          r;
        int          k;
        settle();
        write_delay(d);
        @(posedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        t   = $urandom;
        pin = 1'($urandom_range(0, 1));
        for (k = 0; k < n_items; k++) begin
            if (k == hold_at) begin
                hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                offer_request(make_req(t_req'(2'($urandom_range(0, 3))),
                                       1'($urandom_range(0, 1)), $urandom));
            end else if (r < 10) begin
                offer_request(make_req(REQ_IRQ, 1'($urandom_range(0, 1)), t));
            end else if (r < 20) begin
                offer_request(make_req(REQ_READ, 1'($urandom_range(0, 1)), t));
            end else if (r < 23) begin
                pin = 1'($urandom_range(0, 1));
                offer_request(make_req(REQ_RESET, pin, t));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    step = $urandom;
                end else if (r < 13) begin
                    step = d + $urandom_range(0, 2);
                end else begin
                    step = $urandom_range(0, int'(d) / 4 + 2);
                end
                t = t + step;
                if ($urandom_range(0, 99) < 15) begin
                    pin = ~pin;
                end
                offer_request(make_req(REQ_SAMPLE, pin, t));
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req_item  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // default delay of 50 ms
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'd100));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'd110));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'd160));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'd161));
        offer_request(make_req(REQ_READ, 1'b0, 32'd162));
        offer_request(make_req(REQ_READ, 1'b1, 32'd163));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'd170));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'd175));
        offer_request(make_req(REQ_IRQ, 1'b0, 32'd176));
        offer_request(make_req(REQ_IRQ, 1'b1, 32'd177));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'd180));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'd181));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'd300));
        offer_request(make_req(REQ_RESET, 1'b1, 32'hFFFF_FFC0));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'h0000_0010));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'hFFFF_FFFF));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'h0000_0040));
        offer_request(make_req(REQ_IRQ, 1'b0, 32'h0000_0041));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFF));
        offer_request(make_req(REQ_READ, 1'b1, 32'h0000_0000));
        offer_request(make_req(REQ_IRQ, 1'b1, 32'h0000_0001));
        offer_request(make_req(REQ_RESET, 1'b0, 32'h0000_0000));
        offer_request(make_req(REQ_SAMPLE, 1'b0, 32'h0000_0002));
        offer_request(make_req(REQ_SAMPLE, 1'b1, 32'h8000_0000));
        offer_request(make_req(REQ_READ, 1'b0, 32'h8000_0001));

        run_phase(16'd0, 0, 0, 150, -1);
        run_phase(16'd65535, 51, 0, 150, -1);
        run_phase(16'd50, 0, 51, 150, 20);
        run_phase(16'($urandom_range(2, 300)), 12, 12, 150, -1);
        run_phase(16'd1, 0, 0, 150, 60);

        @(negedge clk);
        req_valid <= 1'b0;
        stall_pct = 0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("button_debounce_edge_tracker_tb: PASS");
        end else begin
            $display("button_debounce_edge_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
src/dbt_pkg.sv
src/dbt_in_reg.sv
src/dbt_core.sv
src/button_debounce_edge_tracker.sv
tb/button_debounce_edge_tracker_sb.sv
tb/button_debounce_edge_tracker_tb.sv
